FILE: hw/rtl/bncn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bncn_pkg
// Shared widths and types of the batch-norm channel normaliser.
// ----------------------------------------------------------------------------
package bncn_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int DATA_WIDTH   = 24;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = 7;
  localparam int FRAC_W       = 12;
  // Difference and variance sum each grow by one bit.
  localparam int S_W          = DATA_WIDTH + 1;
  // Square-root operand (sum shifted by the fraction) padded to an even width.
  localparam int RAD_W        = S_W + FRAC_W;
  localparam int R_W          = (RAD_W + 1) / 2;
  localparam int X_W          = 2 * R_W;
  localparam int RS_W         = R_W + 2;
  // Dividend: magnitude shifted by the fraction plus half the divisor.
  localparam int N_W          = S_W + FRAC_W;
  localparam int DR_W         = R_W + 1;

  // Input beat layout: channel, mean, variance and sample from the lowest bit up,
  // padded to whole bytes.
  localparam int MEAN_LSB     = CH_W;
  localparam int VAR_LSB      = MEAN_LSB + DATA_WIDTH;
  localparam int SMP_LSB      = VAR_LSB + DATA_WIDTH;
  localparam int IN_W         = ((SMP_LSB + DATA_WIDTH + 7) / 8) * 8;

  localparam int IDX_W        = 1;
  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
  localparam logic [IDX_W-1:0] REG_EPSILON       = 1'd1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_NORM = 1'b1;

  typedef struct packed {
    logic           valid;
    logic           err;
    logic           neg;
    logic [S_W-1:0] mag;
  } bncn_side_t;

endpackage

FILE: hw/rtl/bncn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bncn_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bncn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/bncn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bncn_front
// Statistics stores, range check, difference and variance sum.
// ----------------------------------------------------------------------------
module bncn_front import bncn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  acc,
  input  logic                  func,
  input  logic [CH_W-1:0]       channel,
  input  logic [DATA_WIDTH-1:0] mean_in,
  input  logic [DATA_WIDTH-1:0] variance_in,
  input  logic [DATA_WIDTH-1:0] sample,
  input  logic [CNT_W-1:0]      channel_count,
  input  logic [DATA_WIDTH-1:0] epsilon,
  output logic [X_W-1:0]        rad,
  output bncn_side_t            side
);

  logic [DATA_WIDTH-1:0] mean_rd;
  logic [DATA_WIDTH-1:0] var_rd;
  logic                  p1_valid;
  logic                  p1_err;
  logic [DATA_WIDTH-1:0] p1_sample;
  logic signed [S_W-1:0] diff;
  logic [S_W-1:0]        ssum;

  bncn_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_CHANNELS)) u_mean (
    .clk(clk), .we(acc && func == FUNC_LOAD), .waddr(channel), .wdata(mean_in),
    .re(en), .raddr(channel), .rdata(mean_rd)
  );

  bncn_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_CHANNELS)) u_var (
    .clk(clk), .we(acc && func == FUNC_LOAD), .waddr(channel), .wdata(variance_in),
    .re(en), .raddr(channel), .rdata(var_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid   <= 1'b0;
      side.valid <= 1'b0;
    end else if (en) begin
      p1_valid   <= acc && func == FUNC_NORM;
      side.valid <= p1_valid;
    end
    if (en) begin
      p1_err    <= {{(CNT_W-CH_W){1'b0}}, channel} >= channel_count;
      p1_sample <= sample;
      side.err  <= p1_err;
      side.neg  <= diff[S_W-1];
      side.mag  <= diff[S_W-1] ? S_W'(-diff) : S_W'(diff);
      rad       <= {{(X_W-RAD_W){1'b0}}, ssum, {FRAC_W{1'b0}}};
    end
  end

  always_comb begin
    diff = S_W'(signed'(p1_sample)) - S_W'(signed'(mean_rd));
    ssum = {1'b0, var_rd} + {1'b0, epsilon};
  end

endmodule

FILE: hw/rtl/bncn_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bncn_sqrt
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module bncn_sqrt import bncn_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [X_W-1:0] rad,
  input  bncn_side_t     side_in,
  output logic [R_W-1:0] root,
  output bncn_side_t     side_out
);

  logic [X_W-1:0]  xs  [R_W+1];
  logic [RS_W-1:0] rem [R_W+1];
  logic [R_W-1:0]  res [R_W+1];
  bncn_side_t      sd  [R_W+1];

  assign xs[0]  = rad;
  assign rem[0] = '0;
  assign res[0] = '0;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < R_W; i++) begin : g_stage
    logic [RS_W-1:0] rem_sh;
    logic [RS_W-1:0] trial;
    logic            take;

    always_comb begin
      rem_sh = {rem[i][RS_W-3:0], xs[i][X_W-1:X_W-2]};
      trial  = {res[i], 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i+1].valid <= 1'b0;
      end else if (en) begin
        sd[i+1].valid <= sd[i].valid;
      end
      if (en) begin
        sd[i+1].err <= sd[i].err;
        sd[i+1].neg <= sd[i].neg;
        sd[i+1].mag <= sd[i].mag;
        xs[i+1]     <= {xs[i][X_W-3:0], 2'b00};
        rem[i+1]    <= take ? rem_sh - trial : rem_sh;
        res[i+1]    <= {res[i][R_W-2:0], take};
      end
    end
  end

  assign root     = res[R_W];
  assign side_out = sd[R_W];

endmodule

FILE: hw/rtl/bncn_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bncn_div
// Rounded pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bncn_div import bncn_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [R_W-1:0] root,
  input  bncn_side_t     side_in,
  output logic [N_W-1:0] quot,
  output logic [R_W-1:0] divisor,
  output bncn_side_t     side_out
);

  logic [N_W-1:0]  num [N_W+1];
  logic [DR_W-1:0] rem [N_W+1];
  logic [N_W-1:0]  q   [N_W+1];
  logic [R_W-1:0]  dv  [N_W+1];
  bncn_side_t      sd  [N_W+1];

  // Adding half the divisor to the dividend gives round to nearest, ties up.
  always_ff @(posedge clk) begin
    if (rst) begin
      sd[0].valid <= 1'b0;
    end else if (en) begin
      sd[0].valid <= side_in.valid;
    end
    if (en) begin
      sd[0].err <= side_in.err;
      sd[0].neg <= side_in.neg;
      sd[0].mag <= side_in.mag;
      num[0]    <= {side_in.mag, {FRAC_W{1'b0}}} + N_W'(root >> 1);
      dv[0]     <= root;
    end
  end

  assign rem[0] = '0;
  assign q[0]   = '0;

  for (genvar i = 0; i < N_W; i++) begin : g_stage
    logic [DR_W-1:0] rem_sh;
    logic            take;

    always_comb begin
      rem_sh = {rem[i][DR_W-2:0], num[i][N_W-1]};
      take   = rem_sh >= {1'b0, dv[i]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i+1].valid <= 1'b0;
      end else if (en) begin
        sd[i+1].valid <= sd[i].valid;
      end
      if (en) begin
        sd[i+1].err <= sd[i].err;
        sd[i+1].neg <= sd[i].neg;
        sd[i+1].mag <= sd[i].mag;
        dv[i+1]     <= dv[i];
        num[i+1]    <= {num[i][N_W-2:0], 1'b0};
        rem[i+1]    <= take ? rem_sh - {1'b0, dv[i]} : rem_sh;
        q[i+1]      <= {q[i][N_W-2:0], take};
      end
    end
  end

  assign quot     = q[N_W];
  assign divisor  = dv[N_W];
  assign side_out = sd[N_W];

endmodule

FILE: hw/rtl/batchnorm_channel_normalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batchnorm_channel_normalize
// Batch-norm inference: (sample - mean) / sqrt(variance + epsilon), Q12.12.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle. A load beat (tuser 0) writes the
// channel's mean and variance into two 64-entry RAMs and gives no result; a
// sample beat (tuser 1) passes through 60 register stages, the first loaded
// at the edge that takes the beat: two stages for the RAM read and
// difference, 19 square-root stages, 38 divider stages and the output
// register. Back-pressure on the output stalls the whole pipeline, so
// throughput stays at one beat per cycle whenever the output is taken. A
// sample whose channel is at or beyond channel_count returns 0 with tuser 1.
// Reading a channel that was never loaded returns an undefined value.
module batchnorm_channel_normalize import bncn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // channel[5:0], mean_in[29:6], variance_in[53:30], sample[77:54], zero pad
  input  logic [IN_W-1:0]       s_axis_tdata,
  // func
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // normalized[23:0]
  output logic [DATA_WIDTH-1:0] m_axis_tdata,
  // status
  output logic                  m_axis_tuser,
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data
);

  localparam logic [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [N_W-1:0]        NEG_LIM = N_W'(SMIN);

  logic [CNT_W-1:0]      channel_count;
  logic [DATA_WIDTH-1:0] epsilon;
  logic                  en;
  logic                  acc;
  logic [X_W-1:0]        rad;
  bncn_side_t            side_f;
  bncn_side_t            side_s;
  bncn_side_t            side_d;
  logic [R_W-1:0]        root;
  logic [N_W-1:0]        quot;
  logic [R_W-1:0]        divisor;
  logic [DATA_WIDTH-1:0] result;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CNT_W'(MAX_CHANNELS);
      epsilon       <= DATA_WIDTH'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CNT_W-1:0];
        REG_EPSILON:       epsilon <= cfg_data;
        default:           ;
      endcase
    end
  end

  bncn_front u_front (
    .clk(clk), .rst(rst), .en(en), .acc(acc), .func(s_axis_tuser),
    .channel(s_axis_tdata[CH_W-1:0]), .mean_in(s_axis_tdata[VAR_LSB-1:MEAN_LSB]),
    .variance_in(s_axis_tdata[SMP_LSB-1:VAR_LSB]),
    .sample(s_axis_tdata[SMP_LSB+DATA_WIDTH-1:SMP_LSB]),
    .channel_count(channel_count), .epsilon(epsilon), .rad(rad), .side(side_f)
  );

  bncn_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .rad(rad), .side_in(side_f),
    .root(root), .side_out(side_s)
  );

  bncn_div u_div (
    .clk(clk), .rst(rst), .en(en), .root(root), .side_in(side_s),
    .quot(quot), .divisor(divisor), .side_out(side_d)
  );

  always_comb begin
    if (side_d.err) begin
      result = '0;
    end else if (divisor == '0) begin
      if (side_d.mag == '0) begin
        result = '0;
      end else begin
        result = side_d.neg ? SMIN : SMAX;
      end
    end else if (side_d.neg) begin
      result = (quot > NEG_LIM) ? SMIN : DATA_WIDTH'(-quot);
    end else begin
      result = (quot > N_W'(SMAX)) ? SMAX : quot[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= side_d.valid;
    end
    if (en) begin
      m_axis_tdata <= result;
      m_axis_tuser <= side_d.err ? STATUS_RANGE : STATUS_OK;
    end
  end

endmodule

FILE: hw/rtl/bncn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bncn_checker
// Port-level checks of the normaliser, bound to the top level.
// ----------------------------------------------------------------------------
module bncn_checker import bncn_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [DATA_WIDTH-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  // A stalled result beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // An out-of-range beat always carries zero data.
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == STATUS_RANGE |-> m_axis_tdata == '0)
    else $error("out-of-range result with non-zero data");

  // The input is never held off while the output is empty or being taken.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled without output back-pressure");

  // No result leaves straight after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind batchnorm_channel_normalize bncn_checker u_bncn_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
